>>> rtl/core/bsme_pkg.sv
`default_nettype none

package bsme_pkg;

	// Table size and field widths.
	localparam int MAX_BINS_DEF = 64;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 16;

	// Window limits and fixed answers.
	localparam logic [COUNT_W-1:0] TOTAL_LIMIT = 16'hFFFF;
	localparam logic [VALUE_W-1:0] EMPTY_ANSWER = 32'hFFFF0000;
	localparam int SPLIT_FACTOR = 10;

	// Operation codes of an input beat.
	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_QUERY  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// Floor of the average of two signed Q16.16 values.
	function automatic logic signed [VALUE_W-1:0] midpoint(
		input logic signed [VALUE_W-1:0] a,
		input logic signed [VALUE_W-1:0] b
	);
		logic signed [VALUE_W:0] s;
		s = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
		return s[VALUE_W:1];
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/binned_sliding_median_estimator_core.sv
// Binned sliding median estimator: a sorted bin table in two one-port-read RAMs.
// An insert may be followed by a merge; a query on a non-empty window walks the cursor up or
// down the bins. The core takes one item at a time; busy stays high until the item is finished,
// and every search, shift, scan and cursor step goes through the RAM read port.
// A query result is shown for one cycle with done, in the first cycle that busy is low;
// the receiver cannot stall.
// Reset (arst_n low) empties the window at once; the RAMs need no clearing.
`default_nettype none

module binned_sliding_median_estimator_core #(
	parameter int MAX_BINS = bsme_pkg::MAX_BINS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  operation,
	input  wire logic [31:0] sample_value,
	output logic             done,
	output logic [31:0]      median_value,
	output logic             window_empty
);

	localparam int DEPTH = MAX_BINS + 2;
	localparam int AW = $clog2(DEPTH);
	localparam int IW = AW + 1;
	localparam int CW = bsme_pkg::COUNT_W;
	localparam int VW = bsme_pkg::VALUE_W;
	localparam int PW = CW + IW + 4;

	typedef logic signed [IW-1:0] idx_t;
	typedef logic signed [VW-1:0] val_t;

	typedef enum logic [5:0] {
		S_IDLE, S_LOC0, S_LOC1, S_LOC2, S_LOCM, S_LOCW, S_DISP, S_RDP, S_RDPW,
		S_BUMP, S_NB0, S_NB1, S_NB2, S_SPL_L, S_SPL_H, S_NEW_W, S_DEL_W,
		S_SHIFT, S_MRGCHK, S_MRG, S_MRGW, S_EST, S_EU, S_EUW, S_ED0, S_EDW,
		S_EDC, S_AN0, S_AN1, S_AN2, S_AN3, S_EMIT, S_FIN
	} state_t;

	localparam idx_t I_ZERO = idx_t'(0);
	localparam idx_t I_ONE = idx_t'(1);
	localparam idx_t I_MAX = idx_t'(MAX_BINS);

	state_t state_q, ret_q;
	bsme_pkg::op_t op_q;
	val_t v_q, vp_q, vprev_q, vnext_q, a_q, b_q, med_q;
	logic [CW-1:0] total_q, pref_q, cp_q, left_q, prevc_q, bhi_q;
	logic [CW:0] best_q;
	idx_t bins_q, cur_q, lo_q, hi_q, m_q, pos_q, tgt_q, c_q;
	idx_t sh_idx_q, sh_lim_q, wa_q, mi_q, mk_q, bidx_q;
	logic sh_up_q, wp_q, mv_q, hl_q, emp_q, done_q;

	// RAM ports.
	idx_t ra, wa;
	logic we_v, we_c;
	val_t wdv, rd_val;
	logic [CW-1:0] wdc, rd_cnt;

	bsme_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_val_ram (
		.clk(clk), .we(we_v), .waddr(wa[AW-1:0]), .wdata(wdv),
		.raddr(ra[AW-1:0]), .rdata(rd_val)
	);

	bsme_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_cnt_ram (
		.clk(clk), .we(we_c), .waddr(wa[AW-1:0]), .wdata(wdc),
		.raddr(ra[AW-1:0]), .rdata(rd_cnt)
	);

	// Helper values derived from the state registers.
	idx_t nm1, midx, c_cl;
	logic [IW:0] lh;
	logic [CW:0] wsum, msum;
	logic [CW-1:0] want, cnew, half, rest, cdel, lsub;
	logic [PW-1:0] prod, lim10;
	logic sh_in, split_go;
	val_t sum3;

	assign nm1 = bins_q - I_ONE;
	assign lh = {lo_q[IW-1], lo_q} + {hi_q[IW-1], hi_q};
	assign midx = lh[IW:1];
	assign wsum = {1'b0, total_q} + {{CW{1'b0}}, 1'b1};
	assign want = wsum[CW:1];
	assign cnew = cp_q + {{(CW-1){1'b0}}, 1'b1};
	assign half = cp_q >> 1;
	assign rest = cp_q - half;
	assign cdel = (cp_q != '0) ? cp_q - {{(CW-1){1'b0}}, 1'b1} : cp_q;
	assign msum = {1'b0, prevc_q} + {1'b0, rd_cnt};
	assign lsub = (left_q > rd_cnt) ? left_q - rd_cnt : '0;
	assign prod = PW'(cnew) * PW'(bins_q[IW-2:0]);
	assign lim10 = PW'(total_q) * PW'(bsme_pkg::SPLIT_FACTOR);
	assign split_go = (bins_q >= idx_t'(2)) && (prod > lim10);
	assign sh_in = sh_up_q ? (sh_idx_q >= sh_lim_q) : (sh_idx_q <= sh_lim_q);
	assign sum3 = (a_q >>> 2) + (b_q >>> 1) + (rd_val >>> 2);

	// Cursor clamped into the table for the answer.
	always_comb begin
		c_cl = cur_q;
		if (c_cl > nm1) begin
			c_cl = nm1;
		end
		if (c_cl < I_ZERO) begin
			c_cl = I_ZERO;
		end
	end

	// RAM addresses and write data for each step.
	always_comb begin
		ra = I_ZERO;
		wa = I_ZERO;
		we_v = 1'b0;
		we_c = 1'b0;
		wdv = v_q;
		wdc = {{(CW-1){1'b0}}, 1'b1};
		case (state_q)
			S_LOC0: ra = I_ZERO;
			S_LOC1: ra = nm1;
			S_LOCM: ra = midx;
			S_RDP: ra = pos_q;
			S_NB0: ra = (pos_q == I_ZERO) ? I_ZERO : pos_q - I_ONE;
			S_NB1: ra = pos_q + I_ONE;
			S_SHIFT: begin
				ra = sh_in ? sh_idx_q : I_ZERO;
				we_v = wp_q;
				we_c = wp_q;
				wa = wa_q;
				wdv = rd_val;
				wdc = rd_cnt;
			end
			S_NEW_W: begin
				we_v = 1'b1;
				we_c = 1'b1;
				wa = tgt_q;
			end
			S_BUMP: begin
				we_c = 1'b1;
				wa = pos_q;
				wdc = cnew;
			end
			S_SPL_L: begin
				we_v = 1'b1;
				we_c = 1'b1;
				wa = pos_q;
				wdv = (pos_q == I_ZERO) ? vp_q : bsme_pkg::midpoint(vprev_q, vp_q);
				wdc = hl_q ? half : rest;
			end
			S_SPL_H: begin
				we_v = 1'b1;
				we_c = 1'b1;
				wa = pos_q + I_ONE;
				wdv = (pos_q == I_ZERO) ? bsme_pkg::midpoint(vp_q, vnext_q) : vp_q;
				wdc = hl_q ? rest : half;
			end
			S_DEL_W: begin
				we_c = 1'b1;
				wa = pos_q;
				wdc = cdel;
			end
			S_MRG: ra = (mi_q <= I_MAX) ? mi_q : I_ZERO;
			S_MRGW: begin
				we_c = 1'b1;
				wa = bidx_q;
				wdc = best_q[CW-1:0];
			end
			S_EU: ra = cur_q + I_ONE;
			S_ED0: ra = cur_q;
			S_EDC: ra = (cur_q > I_ZERO) ? cur_q - I_ONE : I_ZERO;
			S_AN0: ra = (c_cl == I_ZERO) ? I_ZERO : c_cl - I_ONE;
			S_AN1: ra = c_q;
			S_AN2: ra = c_q + I_ONE;
			default: ra = I_ZERO;
		endcase
	end

	// Sequencer: search, shift, split, merge and cursor walk over the bin RAMs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			op_q <= bsme_pkg::OP_NONE;
			bins_q <= I_ZERO;
			total_q <= '0;
			cur_q <= -I_ONE;
			pref_q <= '0;
			done_q <= 1'b0;
			emp_q <= 1'b0;
			med_q <= '0;
			wp_q <= 1'b0;
			mv_q <= 1'b0;
			sh_up_q <= 1'b0;
			hl_q <= 1'b0;
			v_q <= '0;
			vp_q <= '0;
			vprev_q <= '0;
			vnext_q <= '0;
			a_q <= '0;
			b_q <= '0;
			cp_q <= '0;
			left_q <= '0;
			prevc_q <= '0;
			bhi_q <= '0;
			best_q <= '0;
			lo_q <= I_ZERO;
			hi_q <= I_ZERO;
			m_q <= I_ZERO;
			pos_q <= I_ZERO;
			tgt_q <= I_ZERO;
			c_q <= I_ZERO;
			sh_idx_q <= I_ZERO;
			sh_lim_q <= I_ZERO;
			wa_q <= I_ZERO;
			mi_q <= I_ZERO;
			mk_q <= I_ZERO;
			bidx_q <= I_ZERO;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q <= bsme_pkg::op_t'(operation);
						v_q <= sample_value;
						case (bsme_pkg::op_t'(operation))
							bsme_pkg::OP_INSERT: begin
								state_q <= (total_q == bsme_pkg::TOTAL_LIMIT) ? S_FIN : S_LOC0;
							end
							bsme_pkg::OP_DELETE: begin
								state_q <= (total_q == '0 || bins_q == I_ZERO) ? S_FIN : S_LOC0;
							end
							bsme_pkg::OP_QUERY: begin
								if (total_q == '0) begin
									med_q <= bsme_pkg::EMPTY_ANSWER;
									emp_q <= 1'b1;
									state_q <= S_EMIT;
								end else begin
									emp_q <= 1'b0;
									state_q <= S_EST;
								end
							end
							default: state_q <= S_FIN;
						endcase
					end
				end
				// Binary search for the bin of the sample.
				S_LOC0: begin
					if (bins_q == I_ZERO) begin
						pos_q <= -I_ONE;
						state_q <= S_DISP;
					end else begin
						state_q <= S_LOC1;
					end
				end
				S_LOC1: begin
					if (v_q < rd_val) begin
						pos_q <= -I_ONE;
						state_q <= S_DISP;
					end else begin
						state_q <= S_LOC2;
					end
				end
				S_LOC2: begin
					if (v_q > rd_val) begin
						pos_q <= bins_q;
						state_q <= S_DISP;
					end else begin
						lo_q <= I_ZERO;
						hi_q <= bins_q;
						state_q <= S_LOCM;
					end
				end
				S_LOCM: begin
					if (midx == lo_q) begin
						pos_q <= lo_q;
						state_q <= S_DISP;
					end else begin
						m_q <= midx;
						state_q <= S_LOCW;
					end
				end
				S_LOCW: begin
					if (v_q == rd_val) begin
						pos_q <= m_q;
						state_q <= S_DISP;
					end else begin
						if (v_q > rd_val) begin
							lo_q <= m_q;
						end else begin
							hi_q <= m_q;
						end
						state_q <= S_LOCM;
					end
				end
				S_DISP: begin
					if (op_q == bsme_pkg::OP_INSERT) begin
						total_q <= total_q + {{(CW-1){1'b0}}, 1'b1};
						if (pos_q < I_ZERO) begin
							// New first bin: shift the whole table up by one.
							pref_q <= pref_q + {{(CW-1){1'b0}}, 1'b1};
							cur_q <= cur_q + I_ONE;
							tgt_q <= I_ZERO;
							sh_up_q <= 1'b1;
							sh_idx_q <= nm1;
							sh_lim_q <= I_ZERO;
							wp_q <= 1'b0;
							bins_q <= bins_q + I_ONE;
							ret_q <= S_NEW_W;
							state_q <= S_SHIFT;
						end else if (pos_q >= bins_q) begin
							tgt_q <= bins_q;
							bins_q <= bins_q + I_ONE;
							state_q <= S_NEW_W;
						end else begin
							state_q <= S_RDP;
						end
					end else begin
						if (pos_q < I_ZERO) begin
							pos_q <= I_ZERO;
						end else if (pos_q >= bins_q) begin
							pos_q <= nm1;
						end
						state_q <= S_RDP;
					end
				end
				S_RDP: state_q <= S_RDPW;
				S_RDPW: begin
					vp_q <= rd_val;
					cp_q <= rd_cnt;
					if (op_q == bsme_pkg::OP_DELETE) begin
						state_q <= S_DEL_W;
					end else if (rd_val == v_q || bins_q >= I_MAX) begin
						if (pos_q <= cur_q) begin
							pref_q <= pref_q + {{(CW-1){1'b0}}, 1'b1};
						end
						state_q <= S_BUMP;
					end else begin
						// New bin just above the found one.
						if (cur_q > pos_q) begin
							cur_q <= cur_q + I_ONE;
							pref_q <= pref_q + {{(CW-1){1'b0}}, 1'b1};
						end
						tgt_q <= pos_q + I_ONE;
						sh_up_q <= 1'b1;
						sh_idx_q <= nm1;
						sh_lim_q <= pos_q + I_ONE;
						wp_q <= 1'b0;
						bins_q <= bins_q + I_ONE;
						ret_q <= S_NEW_W;
						state_q <= S_SHIFT;
					end
				end
				S_BUMP: begin
					cp_q <= cnew;
					state_q <= split_go ? S_NB0 : S_MRGCHK;
				end
				// Split: fetch the neighbors, open a slot above, rewrite both halves.
				S_NB0: state_q <= S_NB1;
				S_NB1: begin
					vprev_q <= rd_val;
					state_q <= S_NB2;
				end
				S_NB2: begin
					vnext_q <= rd_val;
					if (pos_q == I_ZERO) begin
						if (cur_q >= I_ZERO) begin
							cur_q <= cur_q + I_ONE;
						end
					end else if (pos_q == nm1) begin
						if (cur_q == nm1) begin
							cur_q <= cur_q + I_ONE;
						end
					end else if (cur_q >= pos_q) begin
						cur_q <= cur_q + I_ONE;
					end
					hl_q <= (pos_q == I_ZERO) ||
						((pos_q != nm1) && ((pos_q + pos_q) < bins_q));
					sh_up_q <= 1'b1;
					sh_idx_q <= nm1;
					sh_lim_q <= pos_q + I_ONE;
					wp_q <= 1'b0;
					bins_q <= bins_q + I_ONE;
					ret_q <= S_SPL_L;
					state_q <= S_SHIFT;
				end
				S_SPL_L: state_q <= S_SPL_H;
				S_SPL_H: state_q <= S_MRGCHK;
				S_NEW_W: state_q <= S_MRGCHK;
				S_DEL_W: begin
					total_q <= total_q - {{(CW-1){1'b0}}, 1'b1};
					if (cur_q >= pos_q && pref_q != '0) begin
						pref_q <= pref_q - {{(CW-1){1'b0}}, 1'b1};
					end
					if (cdel == '0) begin
						if (cur_q >= pos_q) begin
							cur_q <= cur_q - I_ONE;
						end
						sh_up_q <= 1'b0;
						sh_idx_q <= pos_q + I_ONE;
						sh_lim_q <= nm1;
						wp_q <= 1'b0;
						bins_q <= bins_q - I_ONE;
						ret_q <= S_FIN;
						state_q <= S_SHIFT;
					end else begin
						state_q <= S_FIN;
					end
				end
				// Streaming table shift: read one entry, write it one slot over next cycle.
				S_SHIFT: begin
					if (sh_in) begin
						wa_q <= sh_up_q ? sh_idx_q + I_ONE : sh_idx_q - I_ONE;
						wp_q <= 1'b1;
						sh_idx_q <= sh_up_q ? sh_idx_q - I_ONE : sh_idx_q + I_ONE;
					end else begin
						wp_q <= 1'b0;
						if (!wp_q) begin
							state_q <= ret_q;
						end
					end
				end
				S_MRGCHK: begin
					if (bins_q == I_MAX + I_ONE) begin
						mi_q <= I_ZERO;
						mv_q <= 1'b0;
						state_q <= S_MRG;
					end else begin
						state_q <= S_FIN;
					end
				end
				// Merge scan: the first adjacent pair with the smallest total.
				S_MRG: begin
					mv_q <= (mi_q <= I_MAX);
					mk_q <= mi_q;
					if (mi_q <= I_MAX) begin
						mi_q <= mi_q + I_ONE;
					end
					if (mv_q) begin
						prevc_q <= rd_cnt;
						if (mk_q != I_ZERO && (mk_q == I_ONE || msum < best_q)) begin
							best_q <= msum;
							bidx_q <= mk_q - I_ONE;
							bhi_q <= rd_cnt;
						end
					end else if (mi_q > I_MAX) begin
						state_q <= S_MRGW;
					end
				end
				S_MRGW: begin
					if (cur_q > bidx_q) begin
						cur_q <= cur_q - I_ONE;
					end else if (cur_q == bidx_q) begin
						pref_q <= pref_q + bhi_q;
					end
					sh_up_q <= 1'b0;
					sh_idx_q <= bidx_q + idx_t'(2);
					sh_lim_q <= nm1;
					wp_q <= 1'b0;
					bins_q <= bins_q - I_ONE;
					ret_q <= S_FIN;
					state_q <= S_SHIFT;
				end
				// Cursor walk toward the middle sample.
				S_EST: begin
					if (pref_q < want) begin
						state_q <= S_EU;
					end else if (pref_q > want && cur_q >= I_ZERO && cur_q < bins_q) begin
						state_q <= S_ED0;
					end else begin
						state_q <= S_AN0;
					end
				end
				S_EU: begin
					state_q <= (pref_q < want && cur_q < nm1) ? S_EUW : S_AN0;
				end
				S_EUW: begin
					cur_q <= cur_q + I_ONE;
					pref_q <= pref_q + rd_cnt;
					state_q <= S_EU;
				end
				S_ED0: begin
					left_q <= pref_q;
					state_q <= S_EDW;
				end
				S_EDW: begin
					left_q <= lsub;
					state_q <= S_EDC;
				end
				S_EDC: begin
					if (left_q > want && cur_q > I_ZERO) begin
						cur_q <= cur_q - I_ONE;
						pref_q <= left_q;
						state_q <= S_EDW;
					end else begin
						state_q <= S_AN0;
					end
				end
				// Answer from the bins around the clamped cursor.
				S_AN0: begin
					c_q <= c_cl;
					state_q <= S_AN1;
				end
				S_AN1: begin
					a_q <= rd_val;
					state_q <= S_AN2;
				end
				S_AN2: begin
					b_q <= rd_val;
					state_q <= S_AN3;
				end
				S_AN3: begin
					if (c_q == nm1) begin
						med_q <= b_q;
					end else if (c_q == I_ZERO) begin
						med_q <= bsme_pkg::midpoint(b_q, rd_val);
					end else if ({1'b0, total_q} == {pref_q, 1'b0}) begin
						med_q <= sum3;
					end else begin
						med_q <= bsme_pkg::midpoint(b_q, rd_val);
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_FIN: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign median_value = med_q;
	assign window_empty = emp_q;

endmodule

`default_nettype wire

>>> rtl/core/bsme_ram.sv
`default_nettype none

module bsme_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 66
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/core/bsme_checker.sv
`default_nettype none

module bsme_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic [1:0]  operation,
	input wire logic [31:0] sample_value,
	input wire logic        done,
	input wire logic [31:0] median_value,
	input wire logic        window_empty
);

	// Every accepted beat raises busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not raise busy");

	// A result follows work: busy in the cycle before done.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without preceding work");

	// A result is a single-cycle pulse.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result held for more than one cycle");

	// The empty flag comes with the fixed answer.
	a_empty_value: assert property (@(posedge clk) disable iff (!arst_n)
		done && window_empty |-> median_value == 32'hFFFF0000)
		else $error("empty window with wrong answer");

	// Only a query yields a result.
	a_query_only: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && operation != bsme_pkg::OP_QUERY |=> !done)
		else $error("result after a non-query beat");

endmodule

bind binned_sliding_median_estimator_core bsme_checker u_bsme_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.operation(operation),
	.sample_value(sample_value),
	.done(done),
	.median_value(median_value),
	.window_empty(window_empty)
);

`default_nettype wire

>>> verif/binned_sliding_median_estimator_core_tb.sv
`timescale 1ns / 100ps

module binned_sliding_median_estimator_core_tb;

	localparam int TABLE_BINS = bsme_pkg::MAX_BINS_DEF;
	localparam int SLOTS = TABLE_BINS + 2;
	localparam int QUIET_LIMIT = 5000;
	localparam int TAIL_CYCLES = 300;

	typedef logic signed [31:0] q16_t;

	typedef struct {
		bsme_pkg::op_t op;
		logic [31:0]   val;
	} sample_beat_t;

	typedef struct {
		logic [31:0] median;
		logic        empty;
	} median_answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  operation = bsme_pkg::OP_INSERT;
	logic [31:0] sample_value = '0;
	wire         busy;
	wire         done;
	wire  [31:0] median_value;
	wire         window_empty;

	binned_sliding_median_estimator_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.sample_value(sample_value),
		.done(done),
		.median_value(median_value),
		.window_empty(window_empty)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	sample_beat_t   pending_beats[$];
	median_answer_t expected_medians[$];
	int             error_count = 0;
	bit             no_idle = 1'b0;

	// Shadow copy of the bin table, window and median cursor.
	q16_t        bin_val[SLOTS];
	int unsigned bin_cnt[SLOTS];
	int          bin_total_used = 0;
	int unsigned held_samples = 0;
	int          cursor_at = -1;
	int unsigned cursor_sum = 0;

	function automatic q16_t floor_shift(longint s, int k);
		longint r;
		r = s >>> k;
		return q16_t'(r);
	endfunction

	function automatic q16_t mid_of(q16_t a, q16_t b);
		return floor_shift(longint'(a) + longint'(b), 1);
	endfunction

	function automatic int find_bin(q16_t v);
		int lo, hi, m;
		lo = 0;
		hi = bin_total_used;
		if (bin_total_used == 0 || v < bin_val[0]) return -1;
		if (v > bin_val[bin_total_used-1]) return bin_total_used;
		forever begin
			m = (lo + hi) / 2;
			if (m == lo) return lo;
			if (v == bin_val[m]) return m;
			if (v > bin_val[m]) lo = m;
			else hi = m;
		end
	endfunction

	function automatic void make_room(int at);
		if (bin_total_used >= SLOTS || at < 0 || at > bin_total_used) return;
		for (int i = bin_total_used; i > at; i--) begin
			bin_val[i] = bin_val[i-1];
			bin_cnt[i] = bin_cnt[i-1];
		end
		bin_total_used++;
	endfunction

	function automatic void drop_bin(int at);
		if (at < 0 || at >= bin_total_used) return;
		for (int i = at; i < bin_total_used - 1; i++) begin
			bin_val[i] = bin_val[i+1];
			bin_cnt[i] = bin_cnt[i+1];
		end
		bin_total_used--;
	endfunction

	function automatic void split_heavy_bin(int p);
		int n;
		int unsigned half, rest;
		n = bin_total_used;
		half = bin_cnt[p] >> 1;
		rest = bin_cnt[p] - half;
		if (p == 0) begin
			make_room(1);
			bin_val[1] = mid_of(bin_val[0], bin_val[2]);
			bin_cnt[0] = half;
			bin_cnt[1] = rest;
			if (cursor_at >= 0) cursor_at++;
		end else if (p == n - 1) begin
			bin_val[n] = bin_val[n-1];
			bin_cnt[n] = half;
			bin_val[n-1] = mid_of(bin_val[n-2], bin_val[n]);
			bin_cnt[n-1] = rest;
			bin_total_used = n + 1;
			if (cursor_at == n - 1) cursor_at++;
		end else if (2 * p < n) begin
			make_room(p);
			bin_val[p] = mid_of(bin_val[p-1], bin_val[p+1]);
			bin_cnt[p] = half;
			bin_cnt[p+1] = rest;
			if (cursor_at >= p) cursor_at++;
		end else begin
			make_room(p + 1);
			bin_val[p+1] = bin_val[p];
			bin_val[p] = mid_of(bin_val[p-1], bin_val[p+1]);
			bin_cnt[p+1] = half;
			bin_cnt[p] = rest;
			if (cursor_at >= p) cursor_at++;
		end
	endfunction

	// Fold the lightest adjacent pair; the earliest one wins a tie.
	function automatic void merge_lightest_pair();
		int unsigned best, s;
		int idx;
		best = bin_cnt[0] + bin_cnt[1];
		idx = 0;
		for (int i = 1; i < TABLE_BINS; i++) begin
			s = bin_cnt[i] + bin_cnt[i+1];
			if (best > s) begin
				best = s;
				idx = i;
			end
		end
		if (cursor_at > idx) cursor_at--;
		else if (cursor_at == idx) cursor_sum += bin_cnt[idx+1];
		bin_cnt[idx] = best;
		drop_bin(idx + 1);
	endfunction

	function automatic void add_sample(q16_t v);
		int pos, n;
		if (held_samples >= bsme_pkg::TOTAL_LIMIT) return;
		pos = find_bin(v);
		n = bin_total_used;
		held_samples++;
		if (pos < 0) begin
			make_room(0);
			bin_val[0] = v;
			bin_cnt[0] = 1;
			cursor_sum++;
			cursor_at++;
		end else if (pos >= n) begin
			bin_val[n] = v;
			bin_cnt[n] = 1;
			bin_total_used = n + 1;
		end else if (bin_val[pos] == v || n >= TABLE_BINS) begin
			if (pos <= cursor_at) cursor_sum++;
			bin_cnt[pos]++;
			if (n >= 2 && longint'(bin_cnt[pos]) * n >
					longint'(bsme_pkg::SPLIT_FACTOR) * held_samples)
				split_heavy_bin(pos);
		end else begin
			if (cursor_at > pos) begin
				cursor_at++;
				cursor_sum++;
			end
			make_room(pos + 1);
			bin_val[pos+1] = v;
			bin_cnt[pos+1] = 1;
		end
		if (bin_total_used == TABLE_BINS + 1) merge_lightest_pair();
	endfunction

	function automatic void remove_sample(q16_t v);
		int pos;
		if (held_samples == 0 || bin_total_used == 0) return;
		pos = find_bin(v);
		if (pos < 0) pos = 0;
		if (pos >= bin_total_used) pos = bin_total_used - 1;
		if (bin_cnt[pos] > 0) bin_cnt[pos]--;
		held_samples--;
		if (cursor_at >= pos && cursor_sum > 0) cursor_sum--;
		if (bin_cnt[pos] == 0) begin
			drop_bin(pos);
			if (cursor_at >= pos) cursor_at--;
		end
	endfunction

	// Walk the cursor to the middle sample and interpolate around it.
	function automatic q16_t walk_to_median();
		int n, c;
		int unsigned want, k, left;
		n = bin_total_used;
		want = (held_samples + 1) >> 1;
		if (cursor_sum < want) begin
			while (cursor_sum < want && cursor_at < n - 1) begin
				cursor_at++;
				cursor_sum += bin_cnt[cursor_at];
			end
		end else if (cursor_sum > want && cursor_at >= 0 && cursor_at < n) begin
			k = bin_cnt[cursor_at];
			left = (cursor_sum > k) ? cursor_sum - k : 0;
			while (left > want && cursor_at > 0) begin
				cursor_at--;
				cursor_sum = left;
				k = bin_cnt[cursor_at];
				left = (left > k) ? left - k : 0;
			end
		end
		c = cursor_at;
		if (c > n - 1) c = n - 1;
		if (c < 0) c = 0;
		if (c == n - 1) return bin_val[c];
		if (c == 0) return mid_of(bin_val[0], bin_val[1]);
		if (held_samples == 2 * cursor_sum)
			return floor_shift(bin_val[c-1], 2) + floor_shift(bin_val[c], 1)
				+ floor_shift(bin_val[c+1], 2);
		return mid_of(bin_val[c], bin_val[c+1]);
	endfunction

	function automatic void apply_beat(logic [1:0] op, logic [31:0] val);
		median_answer_t ans;
		case (bsme_pkg::op_t'(op))
			bsme_pkg::OP_INSERT: add_sample(q16_t'(val));
			bsme_pkg::OP_DELETE: remove_sample(q16_t'(val));
			bsme_pkg::OP_QUERY: begin
				if (held_samples == 0) begin
					ans.median = bsme_pkg::EMPTY_ANSWER;
					ans.empty = 1'b1;
				end else begin
					ans.median = walk_to_median();
					ans.empty = 1'b0;
				end
				expected_medians.push_back(ans);
			end
			default: ;
		endcase
	endfunction

	// Driver: present queued beats, with random idle bursts unless no_idle is set.
	int idle_left = 0;
	always @(posedge clk) begin
		sample_beat_t nxt;
		logic taken;
		taken = start && !busy;
		if (taken) apply_beat(operation, sample_value);
		if (!arst_n) begin
			start <= 1'b0;
		end else if (idle_left > 0) begin
			idle_left <= idle_left - 1;
			start <= 1'b0;
		end else if (start && !taken) begin
			start <= 1'b1;
		end else if (pending_beats.size() > 0) begin
			if (!no_idle && $urandom_range(0, 9) == 0) begin
				idle_left <= $urandom_range(0, 5);
				start <= 1'b0;
			end else begin
				nxt = pending_beats.pop_front();
				start <= 1'b1;
				operation <= nxt.op;
				sample_value <= nxt.val;
			end
		end else begin
			start <= 1'b0;
		end
	end

	// Monitor: compare each done beat with the oldest expected median.
	always @(posedge clk) begin
		median_answer_t want;
		if (arst_n && done) begin
			if (expected_medians.size() == 0) begin
				$display("%0t: unexpected result median %h empty %b", $time,
					median_value, window_empty);
				error_count++;
			end else begin
				want = expected_medians.pop_front();
				if (median_value !== want.median) begin
					$display("%0t: median_value expected %h actual %h", $time,
						want.median, median_value);
					error_count++;
				end
				if (window_empty !== want.empty) begin
					$display("%0t: window_empty expected %b actual %b", $time,
						want.empty, window_empty);
					error_count++;
				end
			end
		end
	end

	// Watchdog on cycles with no beat moving either way.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("binned_sliding_median_estimator_core_tb: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic queue_beat(bsme_pkg::op_t op, logic [31:0] val);
		sample_beat_t b;
		b.op = op;
		b.val = val;
		pending_beats.push_back(b);
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (pending_beats.size() != 0 || start || expected_medians.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_sample(logic [31:0] recent[$]);
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			2, 3: begin
				if (recent.size() > 0) return recent[$urandom_range(0, recent.size() - 1)];
				return $urandom();
			end
			default: return (32'($urandom_range(0, 800)) - 32'd400) << 12;
		endcase
	endfunction

	initial begin
		logic [31:0] recent[$];
		logic [31:0] v;
		int unsigned r;
		int drain_count;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty window, extremes, out-of-table deletes, unused code.
		queue_beat(bsme_pkg::OP_QUERY, 32'h0);
		queue_beat(bsme_pkg::OP_DELETE, 32'h1234_5678);
		queue_beat(bsme_pkg::OP_NONE, 32'hFFFF_FFFF);
		queue_beat(bsme_pkg::OP_INSERT, 32'h7FFF_FFFF);
		queue_beat(bsme_pkg::OP_QUERY, 32'h0);
		queue_beat(bsme_pkg::OP_INSERT, 32'h8000_0000);
		queue_beat(bsme_pkg::OP_QUERY, 32'h0);
		queue_beat(bsme_pkg::OP_INSERT, 32'h0000_0000);
		queue_beat(bsme_pkg::OP_INSERT, 32'h0001_0000);
		queue_beat(bsme_pkg::OP_INSERT, 32'h0001_0000);
		queue_beat(bsme_pkg::OP_QUERY, 32'hFFFF_FFFF);
		queue_beat(bsme_pkg::OP_DELETE, 32'h8000_0000);
		queue_beat(bsme_pkg::OP_DELETE, 32'h7FFF_FFFF);
		queue_beat(bsme_pkg::OP_QUERY, 32'h0);
		queue_beat(bsme_pkg::OP_INSERT, 32'hFFFF_0000);
		queue_beat(bsme_pkg::OP_DELETE, 32'h8000_0001);
		queue_beat(bsme_pkg::OP_DELETE, 32'h7FFF_FFFE);
		queue_beat(bsme_pkg::OP_QUERY, 32'h0);
		queue_beat(bsme_pkg::OP_DELETE, 32'h0);
		queue_beat(bsme_pkg::OP_DELETE, 32'h0);
		queue_beat(bsme_pkg::OP_QUERY, 32'h0);

		// Directed: a spread of bins, then heavy middle, first and last bins to force splits.
		for (int i = 0; i < 24; i++) queue_beat(bsme_pkg::OP_INSERT, 32'(i) << 16);
		for (int i = 0; i < 25; i++) queue_beat(bsme_pkg::OP_INSERT, 32'h000C_0000);
		queue_beat(bsme_pkg::OP_QUERY, 32'h0);
		for (int i = 0; i < 35; i++) queue_beat(bsme_pkg::OP_INSERT, 32'hFFF0_0000);
		queue_beat(bsme_pkg::OP_QUERY, 32'h0);
		for (int i = 0; i < 50; i++) queue_beat(bsme_pkg::OP_INSERT, 32'h0040_0000);
		queue_beat(bsme_pkg::OP_QUERY, 32'h0);

		// Random: sliding-window traffic, clustered values and hot-value bursts.
		for (int i = 0; i < 360; i++) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				v = pick_sample(recent);
				recent.push_back(v);
				queue_beat(bsme_pkg::OP_INSERT, v);
			end else if (r < 65) begin
				if (r < 60 && recent.size() > 0) v = recent.pop_front();
				else v = $urandom();
				queue_beat(bsme_pkg::OP_DELETE, v);
			end else if (r < 90) begin
				queue_beat(bsme_pkg::OP_QUERY, $urandom());
			end else if (r < 95) begin
				v = pick_sample(recent);
				for (int j = 0; j < 8; j++) begin
					recent.push_back(v);
					queue_beat(bsme_pkg::OP_INSERT, v);
				end
				queue_beat(bsme_pkg::OP_QUERY, 32'h0);
			end else begin
				queue_beat(bsme_pkg::OP_NONE, $urandom());
			end
		end

		// Last part: empty the window, then a few extremes around the empty state.
		wait_drained();
		no_idle = 1'b1;
		drain_count = held_samples;
		for (int i = 0; i < drain_count; i++) queue_beat(bsme_pkg::OP_DELETE, $urandom());
		queue_beat(bsme_pkg::OP_QUERY, 32'h0);
		queue_beat(bsme_pkg::OP_INSERT, 32'h0001_8000);
		queue_beat(bsme_pkg::OP_INSERT, 32'h8000_0000);
		queue_beat(bsme_pkg::OP_QUERY, 32'h0);
		queue_beat(bsme_pkg::OP_DELETE, 32'h7FFF_FFFF);
		queue_beat(bsme_pkg::OP_QUERY, 32'h0);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_medians.size() == 0)
			$display("binned_sliding_median_estimator_core_tb: done, clean");
		else
			$display("binned_sliding_median_estimator_core_tb: done, errors");
		$finish;
	end

endmodule
